### rtl/core/bcc_pkg.sv
`default_nettype none

package bcc_pkg;

  // Default drive DAC resolution
  localparam int DAC_BITS_DEF = 12;

  // Indication margin below full / above empty, millivolts
  localparam int IND_MARGIN_MV = 700;

  // Field widths
  localparam int CUR_W  = 13;
  localparam int MV_W   = 14;
  localparam int SUP_W  = 15;
  localparam int LVL_W  = 12;
  localparam int MODE_W = 3;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_ADDR_W = 3;

  // Charger modes
  localparam logic [MODE_W-1:0] M_START = 3'd0;
  localparam logic [MODE_W-1:0] M_PRE   = 3'd1;
  localparam logic [MODE_W-1:0] M_CHG   = 3'd2;
  localparam logic [MODE_W-1:0] M_FULL  = 3'd3;
  localparam logic [MODE_W-1:0] M_DIS   = 3'd4;
  localparam logic [MODE_W-1:0] M_DEEP  = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CUR_LIMIT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FULL_MV     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EMPTY_MV    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PRESENT_MV  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_START_LEVEL = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FINE_STEP   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_COARSE_STEP = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_BAND   = 3'd7;

  // Configuration reset values
  localparam logic [CUR_W-1:0] RST_CUR_LIMIT   = 13'd1000;
  localparam logic [MV_W-1:0]  RST_FULL_MV     = 14'd7200;
  localparam logic [MV_W-1:0]  RST_EMPTY_MV    = 14'd5000;
  localparam logic [SUP_W-1:0] RST_PRESENT_MV  = 15'd2000;
  localparam logic [LVL_W-1:0] RST_START_LEVEL = 12'd600;
  localparam logic [LVL_W-1:0] RST_FINE_STEP   = 12'd10;
  localparam logic [LVL_W-1:0] RST_COARSE_STEP = 12'd100;
  localparam logic [LVL_W-1:0] RST_HOLD_BAND   = 12'd100;

  typedef struct packed {
    logic [CUR_W-1:0] charge_current_limit_ma;
    logic [MV_W-1:0]  battery_full_mv;
    logic [MV_W-1:0]  battery_empty_mv;
    logic [SUP_W-1:0] input_present_mv;
    logic [LVL_W-1:0] dac_start_level;
    logic [LVL_W-1:0] fine_step;
    logic [LVL_W-1:0] coarse_step;
    logic [LVL_W-1:0] hold_band_mv;
  } bcc_cfg_t;

  // Charger state apart from the drive level
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              hold;
    logic [1:0]        level;
    logic              red;
  } bcc_ctl_t;

endpackage

`default_nettype wire

### rtl/core/bcc_step.sv
`default_nettype none

// One charger step: indication update, mode transition and drive level move.
module bcc_step
  import bcc_pkg::*;
#(
  parameter int DAC_BITS = DAC_BITS_DEF
) (
  input  bcc_cfg_t              cfg,
  input  logic [CUR_W-1:0]      charge_current_ma,
  input  logic [MV_W-1:0]       battery_mv,
  input  logic [SUP_W-1:0]      supply_mv,
  input  bcc_ctl_t              ctl_cur,
  input  logic [DAC_BITS-1:0]   drive_cur,
  output bcc_ctl_t              ctl_next,
  output logic [DAC_BITS-1:0]   drive_next
);

  localparam int AW = ((DAC_BITS > LVL_W) ? DAC_BITS : LVL_W) + 2;
  localparam logic signed [AW-1:0] DAC_MAX = AW'((1 << DAC_BITS) - 1);

  function automatic logic [DAC_BITS-1:0] clip(input logic signed [AW-1:0] v);
    logic [DAC_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > DAC_MAX) begin
      r = '1;
    end else begin
      r = v[DAC_BITS-1:0];
    end
    return r;
  endfunction

  logic [MODE_W-1:0]     mode_eff;
  logic signed [15:0]    batt_s;
  logic signed [15:0]    full_m_margin;
  logic [SUP_W-1:0]      empty_p_margin;
  logic [SUP_W-1:0]      full_p_band;
  logic signed [15:0]    full_m_band;
  logic                  cur_lo, cur_hi, batt_lo, batt_hi, sup_lo, sup_hi;
  logic signed [AW-1:0]  fine_s, coarse_s, start_s, delta, dac_sum;
  logic                  do_move, do_load;

  assign mode_eff = (ctl_cur.mode > M_DEEP) ? M_START : ctl_cur.mode;

  assign batt_s         = $signed({2'b00, battery_mv});
  assign full_m_margin  = $signed({2'b00, cfg.battery_full_mv}) - 16'(IND_MARGIN_MV);
  assign empty_p_margin = {1'b0, cfg.battery_empty_mv} + 15'(IND_MARGIN_MV);
  assign full_p_band    = {1'b0, cfg.battery_full_mv} + {3'b000, cfg.hold_band_mv};
  assign full_m_band    = $signed({2'b00, cfg.battery_full_mv})
                        - $signed({4'b0000, cfg.hold_band_mv});

  assign cur_lo  = charge_current_ma < cfg.charge_current_limit_ma;
  assign cur_hi  = charge_current_ma > cfg.charge_current_limit_ma;
  assign batt_lo = battery_mv < cfg.battery_full_mv;
  assign batt_hi = battery_mv > cfg.battery_full_mv;
  assign sup_lo  = supply_mv < cfg.input_present_mv;
  assign sup_hi  = supply_mv > cfg.input_present_mv;

  assign fine_s   = $signed(AW'(cfg.fine_step));
  assign coarse_s = $signed(AW'(cfg.coarse_step));
  assign start_s  = $signed(AW'(cfg.dac_start_level));
  assign dac_sum  = $signed({{(AW-DAC_BITS){1'b0}}, drive_cur}) + delta;

  always_comb begin
    ctl_next = ctl_cur;
    delta    = '0;
    do_move  = 1'b0;
    do_load  = 1'b0;

    // Indication from the mode held before the step; keep it at or above full
    if ({1'b0, battery_mv} < empty_p_margin) begin
      ctl_next.level = 2'd1;
      ctl_next.red   = (mode_eff == M_DIS) || (mode_eff == M_DEEP);
    end else if (batt_s < full_m_margin) begin
      ctl_next.level = 2'd2;
      ctl_next.red   = (mode_eff == M_DIS) || (mode_eff == M_DEEP);
    end else if (batt_lo) begin
      ctl_next.level = 2'd3;
      ctl_next.red   = (mode_eff == M_DIS) || (mode_eff == M_DEEP);
    end

    ctl_next.mode = mode_eff;
    unique case (mode_eff)
      M_PRE: begin
        if (cur_lo && batt_lo) begin
          delta   = coarse_s;
          do_move = 1'b1;
        end else if (cur_hi || batt_hi) begin
          delta         = -coarse_s;
          do_move       = 1'b1;
          ctl_next.mode = M_CHG;
        end
      end
      M_CHG: begin
        if (cur_lo && batt_lo) begin
          delta   = fine_s;
          do_move = 1'b1;
        end else if (cur_hi && batt_lo) begin
          delta   = -fine_s;
          do_move = 1'b1;
        end
        if (batt_hi) ctl_next.mode = M_FULL;
        if (sup_lo) ctl_next.mode = M_DIS;
      end
      M_FULL: begin
        if (sup_lo) ctl_next.mode = M_DIS;
        if ({1'b0, battery_mv} > full_p_band) begin
          delta   = -fine_s;
          do_move = 1'b1;
        end else if (batt_s < full_m_band) begin
          delta   = fine_s;
          do_move = 1'b1;
        end
      end
      M_DIS: begin
        do_load = 1'b1;
        if (battery_mv < cfg.battery_empty_mv) ctl_next.mode = M_DEEP;
        if (sup_hi) ctl_next.mode = M_PRE;
      end
      M_DEEP: begin
        ctl_next.hold = 1'b0;
      end
      default: begin
        ctl_next.hold = 1'b1;
        do_load       = 1'b1;
        if (sup_hi) begin
          ctl_next.mode = M_PRE;
        end else if (sup_lo) begin
          ctl_next.mode = M_DIS;
        end
      end
    endcase
  end

  always_comb begin
    if (do_load) begin
      drive_next = clip(start_s);
    end else if (do_move) begin
      drive_next = clip(dac_sum);
    end else begin
      drive_next = drive_cur;
    end
  end

endmodule

`default_nettype wire

### rtl/core/battery_charge_controller_top.sv
`default_nettype none

// CC/CV battery charger controller. Each input beat is one measurement sample
// (charge current in mA, battery and supply voltage in mV); each sample yields
// exactly one output beat with the new DAC drive level, the charger mode
// (0 start, 1 precharge, 2 constant-current charge, 3 full, 4 discharge,
// 5 deep discharge), the self-power hold flag and the charge indication. The
// indication level follows battery_mv, its red flag the mode held before the
// sample. A sample is held in the input register, then the step logic writes
// the charger state, also the output register; a new sample is taken every
// cycle unless m_tready stalls results. Deep discharge drops the power hold and
// stays latched until rst. The user must write configuration registers through
// cfg_we/cfg_addr/cfg_wdata only while no sample is in flight; it is unchecked.
module battery_charge_controller_top
  import bcc_pkg::*;
#(
  parameter int DAC_BITS = DAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Sample stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [12:0] charge_current_ma, [26:13] battery_mv, [41:27] supply_mv
  input  logic [47:0]                        s_tdata,
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [DAC_BITS-1:0] dac_value, then mode_now (3), power_hold (1),
  // level_shown (2), shown_red (1), zero fill to whole bytes
  output logic [((DAC_BITS+14)/8)*8-1:0]     m_tdata,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [CFG_ADDR_W-1:0]              cfg_addr,
  input  logic [CFG_DATA_W-1:0]              cfg_wdata
);

  localparam int OUT_W  = DAC_BITS + 7;
  localparam int OUT_TW = ((DAC_BITS + 14) / 8) * 8;

  // Configuration registers
  bcc_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.charge_current_limit_ma <= RST_CUR_LIMIT;
      cfg.battery_full_mv         <= RST_FULL_MV;
      cfg.battery_empty_mv        <= RST_EMPTY_MV;
      cfg.input_present_mv        <= RST_PRESENT_MV;
      cfg.dac_start_level         <= RST_START_LEVEL;
      cfg.fine_step               <= RST_FINE_STEP;
      cfg.coarse_step             <= RST_COARSE_STEP;
      cfg.hold_band_mv            <= RST_HOLD_BAND;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CUR_LIMIT:   cfg.charge_current_limit_ma <= cfg_wdata[CUR_W-1:0];
        REG_FULL_MV:     cfg.battery_full_mv         <= cfg_wdata[MV_W-1:0];
        REG_EMPTY_MV:    cfg.battery_empty_mv        <= cfg_wdata[MV_W-1:0];
        REG_PRESENT_MV:  cfg.input_present_mv        <= cfg_wdata[SUP_W-1:0];
        REG_START_LEVEL: cfg.dac_start_level         <= cfg_wdata[LVL_W-1:0];
        REG_FINE_STEP:   cfg.fine_step               <= cfg_wdata[LVL_W-1:0];
        REG_COARSE_STEP: cfg.coarse_step             <= cfg_wdata[LVL_W-1:0];
        REG_HOLD_BAND:   cfg.hold_band_mv            <= cfg_wdata[LVL_W-1:0];
      endcase
    end
  end

  // Input register
  logic             in_v;
  logic [CUR_W-1:0] cur_q;
  logic [MV_W-1:0]  batt_q;
  logic [SUP_W-1:0] sup_q;
  logic             step_go;
  logic             s_acc;

  // Advance the held sample when the result slot is empty or being drained
  assign step_go  = in_v && (!m_tvalid || m_tready);
  assign s_tready = !in_v || step_go;
  assign s_acc    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      cur_q  <= s_tdata[12:0];
      batt_q <= s_tdata[26:13];
      sup_q  <= s_tdata[41:27];
    end
  end

  // Charger state doubles as the result register
  bcc_ctl_t            ctl, ctl_next;
  logic [DAC_BITS-1:0] drive, drive_next;
  logic                out_v;

  bcc_step #(
    .DAC_BITS(DAC_BITS)
  ) u_step (
    .cfg               (cfg),
    .charge_current_ma (cur_q),
    .battery_mv        (batt_q),
    .supply_mv         (sup_q),
    .ctl_cur           (ctl),
    .drive_cur         (drive),
    .ctl_next          (ctl_next),
    .drive_next        (drive_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.mode  <= M_START;
      ctl.hold  <= 1'b1;
      ctl.level <= 2'd0;
      ctl.red   <= 1'b0;
      drive     <= '0;
      out_v     <= 1'b0;
    end else begin
      if (step_go) begin
        ctl   <= ctl_next;
        drive <= drive_next;
      end
      // Hold the result beat until taken
      if (step_go) begin
        out_v <= 1'b1;
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = OUT_TW'({ctl.red, ctl.level, ctl.hold, ctl.mode, drive});

  // Deep discharge latches until reset
  a_deep_latch: assert property (@(posedge clk) disable iff (rst)
    (ctl.mode == M_DEEP) |=> (ctl.mode == M_DEEP))
    else $error("deep discharge mode left without reset");

  // Power hold is only dropped in deep discharge
  a_hold_deep: assert property (@(posedge clk) disable iff (rst)
    !ctl.hold |-> (ctl.mode == M_DEEP))
    else $error("power hold low outside deep discharge");

  // Charger state moves only when a sample is stepped
  a_state_still: assert property (@(posedge clk) disable iff (rst)
    !step_go |=> ($stable(ctl) && $stable(drive)))
    else $error("charger state changed without a sample");

  // Output packing width check against fields
  a_pack_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_TW-1:OUT_W] == '0))
    else $error("result padding bits not zero");

endmodule

`default_nettype wire
